[rtl/core/hsdb_pkg.sv]
// Package for the descending byte heap sort core.
// Holds the request and response payload types and the default store capacity.
// No dependencies.
package hsdb_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_flag;
   } req_type;

   typedef struct packed {
      logic [7:0] sorted_byte;
      logic       end_of_run;
      logic       truncated;
   } rsp_type;

endpackage

[rtl/core/heap_sort_descending_bytes_core.sv]
// Descending byte heap sort core: store, in-place min-heap sort and readout.
// Depends on hsdb_pkg for the payload types and the default capacity.
//
// Loading accepts one request per cycle while busy is low. The request that carries
// last_flag closes the set. Up to CAPACITY bytes are kept; later bytes are dropped
// and flagged as truncated on every response of the set. Busy then stays high
// while the set is sorted in place in a single-port-read, single-port-write
// memory. Each sift-down level reads the left child, reads the right child,
// then compares and writes back. The heap build over n stored bytes runs n/2
// sifts and the extraction n-1 sifts, each extraction first swapping the root
// with the tail. Results follow, one per cycle, in descending order, each on
// rsp_item for exactly one cycle while rsp_strobe is high; the receiver
// has no way to hold them off and must take one per cycle. Busy falls in the
// cycle that shows the final result, and a new request may be taken then.
module heap_sort_descending_bytes_core #(
   parameter int CAPACITY = hsdb_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hsdb_pkg::req_type req_item,
   output logic             rsp_strobe,
   output hsdb_pkg::rsp_type rsp_item
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IW = AW + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_V,
      S_LD_V,
      S_CHK,
      S_LEFT,
      S_CMP,
      S_NEXT,
      S_SWAP_A,
      S_SWAP_B,
      S_SWAP_C,
      S_EMIT
   } state_type;

   // heap storage
   logic [7:0]    heap_mem [CAPACITY];
   logic [7:0]    rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;

   state_type     state_ff, state_in;
   logic [IW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [IW-1:0] size_ff, size_in;
   logic [IW-1:0] k_ff, k_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [7:0]    val_ff, val_in;
   logic [7:0]    left_ff, left_in;
   logic          has_right_ff, has_right_in;
   logic          extract_ff, extract_in;
   logic          emit_ff, emit_in;
   logic          emit_last_ff, emit_last_in;
   logic          emit_trunc_ff, emit_trunc_in;

   logic          accept;
   logic [IW-1:0] fill_next;
   logic [IW-1:0] lc_idx;
   logic [IW-1:0] rc_idx;
   logic [7:0]    small_val;
   logic [IW-1:0] small_idx;
   logic          small_moved;

   assign accept = start && (state_ff == S_IDLE);
   assign lc_idx = {pos_ff, 1'b1};
   assign rc_idx = lc_idx + IW'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= heap_mem[mem_raddr];
   end

   // pick the smallest of the sifted value and its children; the sifted value wins ties, then the left child
   always_comb begin
      small_val   = val_ff;
      small_idx   = {1'b0, pos_ff};
      small_moved = 1'b0;
      if (left_ff < small_val) begin
         small_val   = left_ff;
         small_idx   = lc_idx;
         small_moved = 1'b1;
      end
      if (has_right_ff && (rd_data_ff < small_val)) begin
         small_val   = rd_data_ff;
         small_idx   = rc_idx;
         small_moved = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      size_in       = size_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      left_in       = left_ff;
      has_right_in  = has_right_ff;
      extract_in    = extract_ff;
      emit_in       = 1'b0;
      emit_last_in  = 1'b0;
      emit_trunc_in = ovf_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = val_ff;
      mem_raddr     = pos_ff;
      fill_next     = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff < IW'(CAPACITY)) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[AW-1:0];
                  mem_wdata = req_item.byte_value;
                  fill_next = count_ff + IW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               count_in = fill_next;
               if (req_item.last_flag) begin
                  size_in    = fill_next;
                  extract_in = 1'b0;
                  if (fill_next > IW'(1)) begin
                     k_in     = fill_next >> 1;
                     pos_in   = AW'((fill_next >> 1) - IW'(1));
                     state_in = S_RD_V;
                  end else begin
                     k_in     = '0;
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_RD_V: begin
            mem_raddr = pos_ff;
            state_in  = S_LD_V;
         end
         S_LD_V: begin
            val_in   = rd_data_ff;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (lc_idx < size_ff) begin
               mem_raddr = lc_idx[AW-1:0];
               state_in  = S_LEFT;
            end else begin
               // leaf reached: drop the sifted value here
               mem_we    = 1'b1;
               mem_waddr = pos_ff;
               mem_wdata = val_ff;
               state_in  = S_NEXT;
            end
         end
         S_LEFT: begin
            left_in      = rd_data_ff;
            has_right_in = rc_idx < size_ff;
            mem_raddr    = rc_idx[AW-1:0];
            state_in     = S_CMP;
         end
         S_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            if (small_moved) begin
               // promote the smaller child and descend
               mem_wdata = small_val;
               pos_in    = small_idx[AW-1:0];
               state_in  = S_CHK;
            end else begin
               mem_wdata = val_ff;
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            if (!extract_ff) begin
               if (k_ff > IW'(1)) begin
                  k_in     = k_ff - IW'(1);
                  pos_in   = AW'(k_ff - IW'(2));
                  state_in = S_RD_V;
               end else begin
                  k_in       = count_ff;
                  extract_in = 1'b1;
                  state_in   = S_SWAP_A;
               end
            end else if (k_ff > IW'(2)) begin
               k_in     = k_ff - IW'(1);
               state_in = S_SWAP_A;
            end else begin
               k_in     = '0;
               state_in = S_EMIT;
            end
         end
         S_SWAP_A: begin
            mem_raddr = '0;
            state_in  = S_SWAP_B;
         end
         S_SWAP_B: begin
            left_in   = rd_data_ff;
            mem_raddr = AW'(k_ff - IW'(1));
            state_in  = S_SWAP_C;
         end
         S_SWAP_C: begin
            // old root goes to the tail, tail value sifts down from the root
            mem_we    = 1'b1;
            mem_waddr = AW'(k_ff - IW'(1));
            mem_wdata = left_ff;
            val_in    = rd_data_ff;
            pos_in    = '0;
            size_in   = k_ff - IW'(1);
            state_in  = S_CHK;
         end
         S_EMIT: begin
            mem_raddr     = k_ff[AW-1:0];
            emit_in       = 1'b1;
            emit_last_in  = (k_ff == count_ff - IW'(1));
            emit_trunc_in = ovf_ff;
            k_in          = k_ff + IW'(1);
            if (k_ff == count_ff - IW'(1)) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         size_ff       <= '0;
         k_ff          <= '0;
         extract_ff    <= 1'b0;
         has_right_ff  <= 1'b0;
         emit_ff       <= 1'b0;
         emit_last_ff  <= 1'b0;
         emit_trunc_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         size_ff       <= size_in;
         k_ff          <= k_in;
         extract_ff    <= extract_in;
         has_right_ff  <= has_right_in;
         emit_ff       <= emit_in;
         emit_last_ff  <= emit_last_in;
         emit_trunc_ff <= emit_trunc_in;
      end
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      left_ff <= left_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = emit_ff;
   assign rsp_item.sorted_byte = rd_data_ff;
   assign rsp_item.end_of_run  = emit_last_ff;
   assign rsp_item.truncated   = emit_trunc_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IW'(CAPACITY))
      else $error("fill count beyond capacity");

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EMIT))
      else $error("response without readout");

   a_end_then_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.end_of_run |=> !rsp_strobe)
      else $error("response after end of run");

   a_sift_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK || state_ff == S_CMP) |-> ({1'b0, pos_ff} < size_ff))
      else $error("sift position outside heap");

   a_busy_no_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |=> rsp_strobe)
      else $error("readout lost a response");

endmodule

[test/tb_heap_sort_descending_bytes_core.sv]
// Testbench for heap_sort_descending_bytes_core: sends byte sets and checks the sorted output.
// Depends on hsdb_pkg and the core. Expected bytes come from a built-in min-heap sort of
// each accepted set. Random sets run with random request gaps.
module tb_heap_sort_descending_bytes_core;
   timeunit 1ns;
   timeprecision 1ps;

   import hsdb_pkg::*;

   localparam int STORE_DEPTH   = CAPACITY_DEFAULT;
   localparam int TARGET_BYTES  = 380;
   localparam int QUIET_TAIL    = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int REPORT_LIMIT  = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   heap_sort_descending_bytes_core #(.CAPACITY(STORE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #4 clock = ~clock;

   // Byte sets waiting to be sent, and sorted bytes waiting to come back.
   req_type     pending_bytes[$];
   rsp_type     sorted_out[$];

   // Shadow of the core: stored bytes, fill level and drop flag.
   logic [7:0]  heap_bytes[STORE_DEPTH];
   int unsigned stored_count = 0;
   bit          bytes_dropped = 1'b0;

   int unsigned accepted_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_left = 0;
   int unsigned idle_pct = 20;
   int unsigned mode_left = 0;

   function automatic void swap_bytes(int unsigned a, int unsigned b);
      logic [7:0] t;
      t = heap_bytes[a];
      heap_bytes[a] = heap_bytes[b];
      heap_bytes[b] = t;
   endfunction

   // Sift node down within a min-heap of size entries.
   function automatic void sift_min(int unsigned size, int unsigned node);
      int unsigned pos;
      int unsigned least;
      bit          settled;
      pos = node;
      settled = 1'b0;
      while (!settled) begin
         least = pos;
         if (2 * pos + 1 < size && heap_bytes[2 * pos + 1] < heap_bytes[least])
            least = 2 * pos + 1;
         if (2 * pos + 2 < size && heap_bytes[2 * pos + 2] < heap_bytes[least])
            least = 2 * pos + 2;
         if (least == pos) begin
            settled = 1'b1;
         end else begin
            swap_bytes(pos, least);
            pos = least;
         end
      end
   endfunction

   // Store the request's byte; on the closing request sort the set descending and queue it.
   function automatic void absorb_request(req_type r);
      rsp_type     rsp;
      int unsigned k;
      if (stored_count < STORE_DEPTH) begin
         heap_bytes[stored_count] = r.byte_value;
         stored_count++;
      end else begin
         bytes_dropped = 1'b1;
      end
      if (r.last_flag) begin
         for (k = stored_count / 2; k > 0; k--)
            sift_min(stored_count, k - 1);
         for (k = stored_count; k > 1; k--) begin
            swap_bytes(0, k - 1);
            sift_min(k - 1, 0);
         end
         for (k = 0; k < stored_count; k++) begin
            rsp.sorted_byte = heap_bytes[k];
            rsp.end_of_run  = (k + 1 == stored_count);
            rsp.truncated   = bytes_dropped;
            sorted_out.push_back(rsp);
         end
         stored_count  = 0;
         bytes_dropped = 1'b0;
      end
   endfunction

   task automatic push_byte(logic [7:0] value, bit last);
      req_type r;
      r.byte_value = value;
      r.last_flag  = last;
      pending_bytes.push_back(r);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: pick_byte = 8'h00;
         1: pick_byte = 8'hFF;
         2: pick_byte = 8'($urandom_range(0, 3));
         default: pick_byte = 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic note_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s: expected byte %0d end %0b trunc %0b, got byte %0d end %0b trunc %0b",
                  what, want.sorted_byte, want.end_of_run, want.truncated,
                  got.sorted_byte, got.end_of_run, got.truncated);
   endtask

   // Driver: hold the request while busy, then either idle or offer the next byte.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            absorb_request(req_item);
            accepted_count++;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 45;
            endcase
         end
         mode_left--;
         if (gap_left == 0 && pending_bytes.size() > QUIET_TAIL &&
             $urandom_range(0, 99) < idle_pct)
            gap_left = $urandom_range(1, 10);
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_item <= pending_bytes.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed response must match the oldest expected byte.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (sorted_out.size() == 0) begin
            note_mismatch("unexpected response", '0, rsp_item);
         end else if (rsp_item.sorted_byte !== sorted_out[0].sorted_byte ||
                      rsp_item.end_of_run !== sorted_out[0].end_of_run ||
                      rsp_item.truncated !== sorted_out[0].truncated) begin
            note_mismatch("response mismatch", sorted_out.pop_front(), rsp_item);
         end else begin
            void'(sorted_out.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int unsigned total_bytes;
      int unsigned made;
      int unsigned set_index;
      int unsigned set_len;
      int unsigned k;

      // Single-byte sets at both extremes, two-byte sets in both orders.
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      // Duplicates only.
      for (k = 0; k < 3; k++)
         push_byte(8'h07, k == 2);
      // Ascending input, then a set of alternating and single-bit patterns.
      for (k = 1; k <= 5; k++)
         push_byte(8'(k * 40), k == 5);
      push_byte(8'hAA, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b1);

      // Random sets: mostly short, with a full set and overflowing sets mixed in.
      made = pending_bytes.size();
      set_index = 0;
      while (made < TARGET_BYTES) begin
         if (set_index == 3)
            set_len = STORE_DEPTH;
         else if (set_index == 7 || set_index == 15)
            set_len = STORE_DEPTH + $urandom_range(1, 8);
         else if ($urandom_range(0, 9) < 8)
            set_len = $urandom_range(1, 12);
         else
            set_len = $urandom_range(13, STORE_DEPTH + 6);
         for (k = 0; k < set_len; k++)
            push_byte(pick_byte(), k + 1 == set_len);
         made += set_len;
         set_index++;
      end
      total_bytes = pending_bytes.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_bytes)
         @(posedge clock);
      while (sorted_out.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && sorted_out.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
